### src/rwpc_pkg.sv
// Package for the rolling window pulse counter.
// Holds the item structs, operation and register codes and default sizes.
// No dependencies.
package rwpc_pkg;

  localparam int IDX_W     = 8;
  localparam int CFG_IDX_W = 3;
  localparam int DATA_W    = 8;

  localparam int DEF_BIN_DEPTH   = 256;
  localparam int DEF_RAIN_SLOTS  = 180;
  localparam int DEF_COUNT_WIDTH = 16;

  // Highest bin index before the wrap when a fixed-window sensor is present.
  localparam logic [IDX_W-1:0] FIXED_LIMIT = 8'd60;
  localparam logic [7:0] FILTER_LEN_RST = 8'd60;

  localparam logic [7:0] TYPE_FIXED  = 8'd7;
  localparam logic [7:0] TYPE_FILTER = 8'd33;

  localparam logic [2:0] OP_TICK      = 3'd0;
  localparam logic [2:0] OP_LIGHT     = 3'd1;
  localparam logic [2:0] OP_RAIN      = 3'd2;
  localparam logic [2:0] OP_CO2       = 3'd3;
  localparam logic [2:0] OP_READ_BINS = 3'd4;
  localparam logic [2:0] OP_READ_RAIN = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_TYPE_A     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TYPE_B     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TYPE_C     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_LEN = 3'd3;

  typedef struct packed {
    logic [2:0]       operation;
    logic [IDX_W-1:0] read_index;
  } rwpc_in_t;

  typedef struct packed {
    logic [7:0]  bin_index;
    logic [15:0] light_count;
    logic [15:0] co2_count;
    logic [15:0] pulse_count;
    logic [7:0]  rain_value;
    logic [7:0]  rain_slot;
  } rwpc_out_t;

  typedef struct packed {
    logic       any_fixed;
    logic       any_filter;
    logic [7:0] filter_length;
  } rwpc_cfg_t;

endpackage

### src/rwpc_cfg_regs.sv
// Configuration registers of the rolling window pulse counter.
// Decodes the sensor types into wrap-rule flags. Depends on rwpc_pkg.
module rwpc_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rwpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rwpc_pkg::DATA_W-1:0]    cfg_data,
  output rwpc_pkg::rwpc_cfg_t            flags
);
  import rwpc_pkg::*;

  logic [7:0] type_a_r;
  logic [7:0] type_b_r;
  logic [7:0] type_c_r;
  logic [7:0] filter_len_r;
  logic       wr;

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      type_a_r     <= '0;
      type_b_r     <= '0;
      type_c_r     <= '0;
      filter_len_r <= FILTER_LEN_RST;
    end else if (wr) begin
      case (cfg_index)
        CFG_TYPE_A:     type_a_r     <= cfg_data;
        CFG_TYPE_B:     type_b_r     <= cfg_data;
        CFG_TYPE_C:     type_c_r     <= cfg_data;
        CFG_FILTER_LEN: filter_len_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    flags.any_fixed     = (type_a_r == TYPE_FIXED) || (type_b_r == TYPE_FIXED) ||
                          (type_c_r == TYPE_FIXED);
    flags.any_filter    = (type_a_r == TYPE_FILTER) || (type_b_r == TYPE_FILTER) ||
                          (type_c_r == TYPE_FILTER);
    flags.filter_length = filter_len_r;
  end

endmodule

### src/rwpc_rd_store.sv
// Memory with per-entry valid bits, a registered read and a bypass of the
// last write. Used for the bin counts and the rain history. Depends on rwpc_pkg.
module rwpc_rd_store #(
  parameter int DEPTH = rwpc_pkg::DEF_RAIN_SLOTS,
  parameter int WIDTH = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       rd_en,
  input  logic [rwpc_pkg::IDX_W-1:0] rd_idx,
  input  logic                       wr_en,
  input  logic [rwpc_pkg::IDX_W-1:0] wr_idx,
  input  logic [WIDTH-1:0]           wr_data,
  output logic [WIDTH-1:0]           q_data
);
  import rwpc_pkg::*;

  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [IDX_W:0] DEPTH_L = (IDX_W + 1)'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [WIDTH-1:0] rd_data_r;
  logic [IDX_W-1:0] q_idx_r;
  logic             byp_vld_r;
  logic [IDX_W-1:0] byp_idx_r;
  logic [WIDTH-1:0] byp_data_r;
  logic             wr_ok;
  logic             rd_ok;
  logic             q_in_range;

  assign wr_ok      = wr_en && ({1'b0, wr_idx} < DEPTH_L);
  assign rd_ok      = rd_en && ({1'b0, rd_idx} < DEPTH_L);
  assign q_in_range = {1'b0, q_idx_r} < DEPTH_L;

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[wr_idx[ADDR_W-1:0]] <= wr_data;
    end
    if (rd_ok) begin
      rd_data_r <= mem[rd_idx[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      byp_vld_r <= 1'b0;
    end else if (wr_ok) begin
      vld_r[wr_idx[ADDR_W-1:0]] <= 1'b1;
      byp_vld_r                 <= 1'b1;
    end
  end

  // The bypass keeps the most recent write, which the memory read issued at
  // the same edge cannot see yet.
  always_ff @(posedge clk) begin
    if (wr_ok) begin
      byp_idx_r  <= wr_idx;
      byp_data_r <= wr_data;
    end
    if (rd_en) begin
      q_idx_r <= rd_idx;
    end
  end

  always_comb begin
    if (!q_in_range) begin
      q_data = '0;
    end else if (byp_vld_r && (byp_idx_r == q_idx_r)) begin
      q_data = byp_data_r;
    end else if (vld_r[q_idx_r[ADDR_W-1:0]]) begin
      q_data = rd_data_r;
    end else begin
      q_data = '0;
    end
  end

endmodule

### src/rolling_window_pulse_counter_top.sv
// Top level of the rolling window pulse counter.
// Depends on rwpc_pkg, rwpc_cfg_regs and rwpc_rd_store.
//
// Items enter on in_valid/in_ready: an operation (tick, light, rain or CO2
// pulse, read of a bin, read of the rain history) and a read index. Every
// item gives exactly one result item on out_valid/out_ready, in order.
// Registers are written on cfg_valid/cfg_ready (always ready); the user must
// write them only while the block is idle, which the block does not enforce.
//
// An accepted item sits in the input stage, where the memory reads issued at
// acceptance come back, and its result is registered in the output register
// when the input stage advances. One item is taken per cycle while out_ready
// keeps the output moving; the counts of the current bin live in registers and
// the bin memory is written back only when a tick leaves that bin.
//
// Reset clears the bin index, the rain pointer, the pending rain count and the
// valid bits of both memories, so every bin and history slot reads as zero;
// no clearing pass is needed. When out_ready is low the result holds, the
// input stage holds behind it and in_ready drops once both are full.
module rolling_window_pulse_counter_top #(
  parameter int BIN_DEPTH   = rwpc_pkg::DEF_BIN_DEPTH,
  parameter int RAIN_SLOTS  = rwpc_pkg::DEF_RAIN_SLOTS,
  parameter int COUNT_WIDTH = rwpc_pkg::DEF_COUNT_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  rwpc_pkg::rwpc_in_t             in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output rwpc_pkg::rwpc_out_t            out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rwpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rwpc_pkg::DATA_W-1:0]    cfg_data
);
  import rwpc_pkg::*;

  localparam int ENTRY_W = 3 * COUNT_WIDTH;
  localparam logic [IDX_W:0] BIN_DEPTH_L  = (IDX_W + 1)'(BIN_DEPTH);
  localparam logic [7:0]     RAIN_SLOTS_L = 8'(RAIN_SLOTS);

  rwpc_cfg_t flags;

  logic       s1_vld_r;
  rwpc_in_t   s1_item_r;
  logic       s1_adv;
  logic       in_acc;
  logic       out_vld_r;
  rwpc_out_t  out_data_r;
  rwpc_out_t  res;

  logic [IDX_W-1:0]       bin_index_r, bin_nxt;
  logic [COUNT_WIDTH-1:0] light_r, light_nxt;
  logic [COUNT_WIDTH-1:0] co2_r, co2_nxt;
  logic [COUNT_WIDTH-1:0] pulse_r, pulse_nxt;
  logic [7:0]             pending_r, pending_nxt;
  logic [7:0]             ptr_r, ptr_nxt;

  logic [IDX_W-1:0]       idx_inc;
  logic [7:0]             slot_base;
  logic                   cur_in_range;
  logic                   is_tick;
  logic [ENTRY_W-1:0]     bin_q;
  logic [7:0]             hist_q;
  logic [COUNT_WIDTH-1:0] view_light, view_co2, view_pulse;

  rwpc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .flags     (flags)
  );

  assign s1_adv   = s1_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !s1_vld_r || s1_adv;
  assign in_acc   = in_valid && in_ready;
  assign is_tick  = s1_item_r.operation == OP_TICK;

  rwpc_rd_store #(
    .DEPTH (BIN_DEPTH),
    .WIDTH (ENTRY_W)
  ) u_bins (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_acc),
    .rd_idx  (in_data.read_index),
    .wr_en   (s1_adv && is_tick),
    .wr_idx  (bin_index_r),
    .wr_data ({light_r, co2_r, pulse_r}),
    .q_data  (bin_q)
  );

  rwpc_rd_store #(
    .DEPTH (RAIN_SLOTS),
    .WIDTH (8)
  ) u_hist (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_acc),
    .rd_idx  (in_data.read_index),
    .wr_en   (s1_adv && is_tick),
    .wr_idx  (slot_base),
    .wr_data (pending_r),
    .q_data  (hist_q)
  );

  always_comb begin
    cur_in_range = {1'b0, bin_index_r} < BIN_DEPTH_L;
    slot_base    = (ptr_r >= RAIN_SLOTS_L) ? 8'd0 : ptr_r;

    idx_inc = bin_index_r + 1'b1;
    if (flags.any_fixed && (idx_inc > FIXED_LIMIT)) begin
      idx_inc = '0;
    end
    if (flags.any_filter && (idx_inc > flags.filter_length)) begin
      idx_inc = '0;
    end

    bin_nxt     = bin_index_r;
    light_nxt   = light_r;
    co2_nxt     = co2_r;
    pulse_nxt   = pulse_r;
    pending_nxt = pending_r;
    ptr_nxt     = ptr_r;

    // The current bin's counts stay zero while the index is beyond the memory.
    case (s1_item_r.operation)
      OP_TICK: begin
        bin_nxt     = idx_inc;
        light_nxt   = '0;
        co2_nxt     = '0;
        pulse_nxt   = '0;
        pending_nxt = '0;
        ptr_nxt     = slot_base + 8'd1;
      end
      OP_LIGHT: begin
        if (cur_in_range) begin
          light_nxt = light_r + 1'b1;
        end
      end
      OP_RAIN: begin
        if (cur_in_range) begin
          pulse_nxt = pulse_r + 1'b1;
        end
        pending_nxt = pending_r + 8'd1;
      end
      OP_CO2: begin
        if (cur_in_range) begin
          co2_nxt = co2_r + 1'b1;
        end
      end
      default: ;
    endcase

    if (s1_item_r.operation == OP_READ_BINS) begin
      if (s1_item_r.read_index == bin_index_r) begin
        view_light = light_r;
        view_co2   = co2_r;
        view_pulse = pulse_r;
      end else begin
        {view_light, view_co2, view_pulse} = bin_q;
      end
    end else begin
      view_light = light_nxt;
      view_co2   = co2_nxt;
      view_pulse = pulse_nxt;
    end

    res.bin_index   = bin_nxt;
    res.light_count = 16'(view_light);
    res.co2_count   = 16'(view_co2);
    res.pulse_count = 16'(view_pulse);
    res.rain_slot   = ptr_nxt;
    if (is_tick) begin
      res.rain_value = pending_r;
    end else if (s1_item_r.operation == OP_READ_RAIN) begin
      res.rain_value = hist_q;
    end else begin
      res.rain_value = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      out_vld_r   <= 1'b0;
      bin_index_r <= '0;
      light_r     <= '0;
      co2_r       <= '0;
      pulse_r     <= '0;
      pending_r   <= '0;
      ptr_r       <= '0;
    end else begin
      if (in_acc) begin
        s1_vld_r <= 1'b1;
      end else if (s1_adv) begin
        s1_vld_r <= 1'b0;
      end
      if (s1_adv) begin
        out_vld_r   <= 1'b1;
        bin_index_r <= bin_nxt;
        light_r     <= light_nxt;
        co2_r       <= co2_nxt;
        pulse_r     <= pulse_nxt;
        pending_r   <= pending_nxt;
        ptr_r       <= ptr_nxt;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r <= in_data;
    end
    if (s1_adv) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

endmodule

### dv/rwpc_checker.sv
// Checker for the rolling window pulse counter: tracks bin, rain and register state,
// predicts one result per accepted item and compares each delivered result against it.
// Depends on rwpc_pkg.
module rwpc_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  rwpc_pkg::rwpc_in_t             in_data,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  rwpc_pkg::rwpc_out_t            out_data,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [rwpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rwpc_pkg::DATA_W-1:0]    cfg_data,
  output int                             fail_count,
  output int                             results_owed
);
  import rwpc_pkg::*;

  localparam int NUM_BINS  = DEF_BIN_DEPTH;
  localparam int NUM_SLOTS = DEF_RAIN_SLOTS;

  logic [7:0]  type_a, type_b, type_c, filt_len;
  logic [7:0]  cur_bin, rain_acc, slot_ptr;
  logic [15:0] light_cnt [NUM_BINS];
  logic [15:0] co2_cnt [NUM_BINS];
  logic [15:0] rain_cnt [NUM_BINS];
  logic [7:0]  rain_log [NUM_SLOTS];
  rwpc_out_t   report_q [$];
  int          fails;

  function automatic logic has_type(logic [7:0] t);
    return type_a == t || type_b == t || type_c == t;
  endfunction

  // Applies one item to the tracked counter state and returns the report it yields.
  function automatic rwpc_out_t advance_counter(rwpc_in_t item);
    rwpc_out_t  res;
    logic [7:0] nxt;
    logic [7:0] view;
    res = '0;
    case (item.operation)
      OP_TICK: begin
        nxt = cur_bin + 8'd1;
        // The fixed-window rule is applied before the filter-length rule.
        if (has_type(TYPE_FIXED) && nxt > FIXED_LIMIT) nxt = 8'd0;
        if (has_type(TYPE_FILTER) && nxt > filt_len) nxt = 8'd0;
        cur_bin = nxt;
        light_cnt[nxt] = '0;
        co2_cnt[nxt]   = '0;
        rain_cnt[nxt]  = '0;
        if (slot_ptr >= NUM_SLOTS) slot_ptr = 8'd0;
        rain_log[slot_ptr] = rain_acc;
        res.rain_value     = rain_acc;
        slot_ptr           = slot_ptr + 8'd1;
        rain_acc           = 8'd0;
      end
      OP_LIGHT: light_cnt[cur_bin] = light_cnt[cur_bin] + 16'd1;
      OP_RAIN: begin
        rain_cnt[cur_bin] = rain_cnt[cur_bin] + 16'd1;
        rain_acc          = rain_acc + 8'd1;
      end
      OP_CO2: co2_cnt[cur_bin] = co2_cnt[cur_bin] + 16'd1;
      OP_READ_RAIN: begin
        if (item.read_index < NUM_SLOTS) res.rain_value = rain_log[item.read_index];
      end
      default: ;
    endcase
    view = (item.operation == OP_READ_BINS) ? item.read_index : cur_bin;
    res.bin_index   = cur_bin;
    res.light_count = light_cnt[view];
    res.co2_count   = co2_cnt[view];
    res.pulse_count = rain_cnt[view];
    res.rain_slot   = slot_ptr;
    return res;
  endfunction

  function automatic int field_bad(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    rwpc_out_t want;
    if (!rst_n) begin
      type_a   = 8'd0;
      type_b   = 8'd0;
      type_c   = 8'd0;
      filt_len = FILTER_LEN_RST;
      cur_bin  = 8'd0;
      rain_acc = 8'd0;
      slot_ptr = 8'd0;
      for (int i = 0; i < NUM_BINS; i++) begin
        light_cnt[i] = '0;
        co2_cnt[i]   = '0;
        rain_cnt[i]  = '0;
      end
      for (int i = 0; i < NUM_SLOTS; i++) rain_log[i] = '0;
      report_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_TYPE_A:     type_a   = cfg_data;
          CFG_TYPE_B:     type_b   = cfg_data;
          CFG_TYPE_C:     type_c   = cfg_data;
          CFG_FILTER_LEN: filt_len = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) report_q.push_back(advance_counter(in_data));
      if (out_valid && out_ready) begin
        if (report_q.size() == 0) begin
          $display("%0t: result with none expected, got bin_index %0d rain_slot %0d",
                   $time, out_data.bin_index, out_data.rain_slot);
          fails++;
        end else begin
          want = report_q.pop_front();
          fails += field_bad("bin_index", 16'(want.bin_index), 16'(out_data.bin_index));
          fails += field_bad("light_count", want.light_count, out_data.light_count);
          fails += field_bad("co2_count", want.co2_count, out_data.co2_count);
          fails += field_bad("pulse_count", want.pulse_count, out_data.pulse_count);
          fails += field_bad("rain_value", 16'(want.rain_value), 16'(out_data.rain_value));
          fails += field_bad("rain_slot", 16'(want.rain_slot), 16'(out_data.rain_slot));
        end
      end
    end
    fail_count   <= fails;
    results_owed <= report_q.size();
  end

endmodule

### dv/rolling_window_pulse_counter_top_tb.sv
// Testbench top for the rolling window pulse counter: clock, reset, register
// phases, item stimulus with random idling, and the final verdict.
// Depends on rwpc_pkg, rolling_window_pulse_counter_top and rwpc_checker.
module rolling_window_pulse_counter_top_tb;
  import rwpc_pkg::*;

  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;
  localparam int DRAIN_CYCLES = 8;
  localparam int LIMIT_CYCLES = 1000000;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  rwpc_in_t             in_data;
  logic                 out_valid;
  logic                 out_ready;
  rwpc_out_t            out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0]    cfg_data;
  int                   fail_count;
  int                   results_owed;
  bit                   idling;

  rolling_window_pulse_counter_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  rwpc_checker u_counter_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .results_owed (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  // Result side: holds ready high for a while and, while idling is on, sometimes drops it for a short burst.
  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (idling && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  task automatic push_item(input logic [2:0] op, input logic [7:0] idx);
    if (idling && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= {op, idx};
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Registers may only change once every outstanding result has been delivered.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [2:0] pick_op(int tick_pct);
    int r;
    if ($urandom_range(0, 99) < tick_pct) return OP_TICK;
    r = $urandom_range(0, 99);
    if (r < 22) return OP_LIGHT;
    if (r < 44) return OP_RAIN;
    if (r < 64) return OP_CO2;
    if (r < 78) return OP_READ_BINS;
    if (r < 92) return OP_READ_RAIN;
    if (r < 96) return OP_SPARE6;
    return OP_SPARE7;
  endfunction

  // Bin reads lean toward low indices, where the short windows keep their counts.
  function automatic logic [7:0] pick_index(logic [2:0] op);
    if (op == OP_READ_BINS && $urandom_range(0, 1) == 1) return 8'($urandom_range(0, 63));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic run_phase(input logic [7:0] ta, input logic [7:0] tb, input logic [7:0] tc,
                           input logic [7:0] flen, input int n_items, input int tick_pct,
                           input bit idle_on);
    logic [2:0] op;
    wait_drained();
    idling <= idle_on;
    write_reg(CFG_TYPE_A, ta);
    write_reg(CFG_TYPE_B, tb);
    write_reg(CFG_TYPE_C, tc);
    write_reg(CFG_FILTER_LEN, flen);
    cfg_valid <= 1'b0;
    repeat (n_items) begin
      op = pick_op(tick_pct);
      push_item(op, pick_index(op));
    end
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    idling    <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset register values: the stores read as zero, including history slots past the ring.
    push_item(OP_READ_BINS, 8'd0);
    push_item(OP_READ_BINS, 8'd255);
    push_item(OP_READ_RAIN, 8'd0);
    push_item(OP_READ_RAIN, 8'd179);
    push_item(OP_READ_RAIN, 8'd180);
    push_item(OP_READ_RAIN, 8'd255);
    push_item(OP_LIGHT, 8'd0);
    push_item(OP_RAIN, 8'd0);
    push_item(OP_CO2, 8'd0);
    push_item(OP_RAIN, 8'd0);
    push_item(OP_SPARE6, 8'hAA);
    push_item(OP_SPARE7, 8'h55);
    push_item(OP_READ_BINS, 8'd0);
    push_item(OP_TICK, 8'd0);
    push_item(OP_READ_RAIN, 8'd0);
    push_item(OP_READ_BINS, 8'd0);
    push_item(OP_LIGHT, 8'd0);
    push_item(OP_TICK, 8'd0);
    push_item(OP_TICK, 8'd0);
    push_item(OP_READ_BINS, 8'd1);
    push_item(OP_READ_RAIN, 8'd1);

    run_phase(8'd7, 8'd0, 8'd0, 8'd60, 110, 70, 1'b1);
    run_phase(8'd0, 8'd33, 8'd0, 8'd0, 40, 25, 1'b1);
    run_phase(8'd0, 8'd0, 8'd33, 8'd255, 40, 25, 1'b1);
    run_phase(8'd33, 8'd7, 8'd0, 8'd100, 40, 30, 1'b1);
    run_phase(8'd0, 8'd33, 8'd7, 8'd12, 40, 40, 1'b1);
    // Long run of ticks with no wrap rule: the bin index rolls over at 8 bits
    // and the rain history pointer goes around its ring.
    run_phase(8'd255, 8'd255, 8'd255, 8'd255, 280, 95, 1'b1);
    run_phase(8'd6, 8'd34, 8'd8, 8'd1, 40, 30, 1'b1);
    run_phase(8'd7, 8'd7, 8'd7, 8'd0, 40, 25, 1'b0);

    // A tick, two pulses in the new bin and a bin read, a tick that stores the
    // pending rain count, then scattered history reads and a last bin read.
    push_item(OP_TICK, 8'd0);
    push_item(OP_LIGHT, 8'd0);
    push_item(OP_RAIN, 8'd0);
    push_item(OP_READ_BINS, 8'd0);
    push_item(OP_TICK, 8'd0);
    repeat (8) push_item(OP_READ_RAIN, 8'($urandom_range(0, 255)));
    push_item(OP_READ_BINS, 8'd0);

    wait_drained();
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
